[rtl/core/lifegen_pkg.sv]
`timescale 1ns / 1ps

package lifegen_pkg;

   localparam int MAX_COLS         = 32;
   localparam int MAX_ROWS_DEFAULT = 1024;
   localparam int COL_W            = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int QUEUE_DEPTH      = 2;

   localparam int ROWS_REG_W = 11;
   localparam int COLS_REG_W = 6;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_ADDR_W = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BOARD_ROWS = 1'b0,
      CSR_BOARD_COLS = 1'b1
   } csr_index_type;

   localparam logic [3:0] BIRTH_COUNT  = 4'd3;
   localparam logic [3:0] SURVIVE_LOW  = 4'd2;
   localparam logic [3:0] SURVIVE_HIGH = 4'd3;

   typedef logic [MAX_COLS-1:0] row_type;

   // One queued job: up to two runs of cells. The first run lies on the middle
   // row, the flush run covers the whole lower row once the board ends.
   typedef struct packed {
      row_type          row_above;
      row_type          row_mid;
      row_type          row_low;
      logic             run_valid;
      logic [COL_W-1:0] run_first;
      logic [COL_W-1:0] run_last;
      logic             flush_valid;
      logic [COL_W-1:0] cols_last;
   } work_type;

endpackage

[rtl/core/lifegen_front.sv]
`timescale 1ns / 1ps

module lifegen_front #(
   parameter int MAX_ROWS = lifegen_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cell_valid,
   input  logic                                cell_alive,
   output logic                                cell_ready,
   input  logic                                csr_we,
   input  lifegen_pkg::csr_index_type          csr_index,
   input  logic [lifegen_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                push_valid,
   output lifegen_pkg::work_type               push_work,
   input  logic                                push_ready
);

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = lifegen_pkg::COL_W;

   logic [ROW_W-1:0]     rows_last_ff, rows_last_in;
   logic [COL_W-1:0]     cols_last_ff, cols_last_in;
   lifegen_pkg::row_type col_mask_ff, col_mask_in;
   logic [ROW_W-1:0]     row_ff;
   logic [COL_W-1:0]     col_ff;
   lifegen_pkg::row_type prev2_ff, prev1_ff, cur_ff, cur_snap;
   logic                 accept;
   logic                 row_end;
   int                   rows_eff;
   int                   cols_eff;

   assign cell_ready = push_ready;
   assign accept     = cell_valid && cell_ready;
   assign row_end    = (col_ff == cols_last_ff);

   always_comb begin
      rows_eff = int'(csr_wdata[lifegen_pkg::ROWS_REG_W-1:0]);
      if (rows_eff == 0) begin
         rows_eff = 1;
      end
      if (rows_eff > MAX_ROWS) begin
         rows_eff = MAX_ROWS;
      end
      cols_eff = int'(csr_wdata[lifegen_pkg::COLS_REG_W-1:0]);
      if (cols_eff == 0) begin
         cols_eff = 1;
      end
      if (cols_eff > lifegen_pkg::MAX_COLS) begin
         cols_eff = lifegen_pkg::MAX_COLS;
      end
      rows_last_in = ROW_W'(rows_eff - 1);
      cols_last_in = COL_W'(cols_eff - 1);
      for (int i = 0; i < lifegen_pkg::MAX_COLS; i++) begin
         col_mask_in[i] = (i < cols_eff);
      end
   end

   always_comb begin
      cur_snap         = cur_ff;
      cur_snap[col_ff] = cell_alive;
   end

   always_comb begin
      push_work.row_above   = (row_ff > ROW_W'(1)) ? (prev2_ff & col_mask_ff) : '0;
      push_work.row_mid     = (row_ff != '0) ? (prev1_ff & col_mask_ff) : '0;
      push_work.row_low     = cur_snap & col_mask_ff;
      push_work.run_valid   = (row_ff != '0) && ((col_ff != '0) || row_end);
      push_work.run_first   = (col_ff == '0) ? '0 : col_ff - COL_W'(1);
      push_work.run_last    = row_end ? col_ff : col_ff - COL_W'(1);
      push_work.flush_valid = row_end && (row_ff == rows_last_ff);
      push_work.cols_last   = cols_last_ff;
      push_valid = accept && (push_work.run_valid || push_work.flush_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= '0;
         cols_last_ff <= '0;
         col_mask_ff  <= lifegen_pkg::row_type'(1);
         row_ff       <= '0;
         col_ff       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            lifegen_pkg::CSR_BOARD_ROWS: begin
               rows_last_ff <= rows_last_in;
            end
            lifegen_pkg::CSR_BOARD_COLS: begin
               cols_last_ff <= cols_last_in;
               col_mask_ff  <= col_mask_in;
            end
         endcase
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= (row_ff == rows_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= cur_snap;
         if (row_end) begin
            prev2_ff <= prev1_ff;
            prev1_ff <= cur_snap;
         end
      end
   end

endmodule

[rtl/core/lifegen_fifo.sv]
`timescale 1ns / 1ps

module lifegen_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  lifegen_pkg::work_type push_work,
   output logic                  push_ready,
   output logic                  pop_valid,
   output lifegen_pkg::work_type pop_work,
   input  logic                  pop
);

   localparam int DEPTH = lifegen_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lifegen_pkg::work_type slots [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_work   = slots[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_work;
      end
   end

endmodule

[rtl/core/lifegen_back.sv]
`timescale 1ns / 1ps

module lifegen_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  work_valid,
   input  lifegen_pkg::work_type work_head,
   output logic                  work_pop,
   output logic                  out_valid,
   output logic                  out_alive,
   output logic                  out_end,
   output logic                  out_done,
   input  logic                  out_ready
);

   localparam int COL_W = lifegen_pkg::COL_W;
   localparam int EXT_W = lifegen_pkg::MAX_COLS + 2;

   lifegen_pkg::work_type work_ff;
   logic                  busy_ff;
   logic                  flush_ff;
   logic [COL_W-1:0]      k_ff;
   logic                  out_valid_ff;
   logic                  out_alive_ff, out_end_ff, out_done_ff;

   lifegen_pkg::row_type  up_row, mid_row, low_row;
   logic [EXT_W-1:0]      up_ext, mid_ext, low_ext;
   logic [2:0]            up_win, mid_win, low_win;
   logic [3:0]            neighbors;
   logic                  next_alive;
   logic                  out_free, step, last_in_run, to_flush, work_done, load;

   assign out_free = !out_valid_ff || out_ready;
   assign step     = busy_ff && out_free;

   always_comb begin
      if (flush_ff) begin
         up_row  = work_ff.row_mid;
         mid_row = work_ff.row_low;
         low_row = '0;
      end else begin
         up_row  = work_ff.row_above;
         mid_row = work_ff.row_mid;
         low_row = work_ff.row_low;
      end
      up_ext  = {1'b0, up_row, 1'b0};
      mid_ext = {1'b0, mid_row, 1'b0};
      low_ext = {1'b0, low_row, 1'b0};
      up_win  = up_ext[k_ff +: 3];
      mid_win = mid_ext[k_ff +: 3];
      low_win = low_ext[k_ff +: 3];
      neighbors = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2])
                + 4'(mid_win[0]) + 4'(mid_win[2])
                + 4'(low_win[0]) + 4'(low_win[1]) + 4'(low_win[2]);
      if (mid_win[1]) begin
         next_alive = (neighbors >= lifegen_pkg::SURVIVE_LOW)
                   && (neighbors <= lifegen_pkg::SURVIVE_HIGH);
      end else begin
         next_alive = (neighbors == lifegen_pkg::BIRTH_COUNT);
      end
   end

   always_comb begin
      last_in_run = flush_ff ? (k_ff == work_ff.cols_last) : (k_ff == work_ff.run_last);
      to_flush    = !flush_ff && last_in_run && work_ff.flush_valid;
      work_done   = last_in_run && !to_flush;
      load        = work_valid && (!busy_ff || (step && work_done));
   end

   assign work_pop  = load;
   assign out_valid = out_valid_ff;
   assign out_alive = out_alive_ff;
   assign out_end   = out_end_ff;
   assign out_done  = out_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= step;
         end
         if (load) begin
            busy_ff <= 1'b1;
         end else if (step && work_done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_alive_ff <= next_alive;
         out_end_ff   <= work_done;
         out_done_ff  <= flush_ff && last_in_run;
      end
      if (load) begin
         work_ff  <= work_head;
         flush_ff <= !work_head.run_valid;
         k_ff     <= work_head.run_valid ? work_head.run_first : '0;
      end else if (step && to_flush) begin
         flush_ff <= 1'b1;
         k_ff     <= '0;
      end else if (step && !work_done) begin
         k_ff <= k_ff + COL_W'(1);
      end
   end

endmodule

[rtl/core/life_automaton_generation.sv]
`timescale 1ns / 1ps
// Channel   Direction  Ports             Payload
// req       in         req_t*            tdata[0] cell_alive
// rsp       out        rsp_t*            tdata[0] next_alive, tlast end_of_run,
//                                        tuser board_done
// csr       in         csr_we/addr/wdata 0 board_rows, 1 board_cols
//
// One cell is accepted per cycle while the two-entry job queue has room; a result
// leaves at most one per cycle from the back end's output register.
// The input that ends the board queues a flush of the last row, one result per column.
// Reset clears positions, queue and output valid; sizes return to one by one.
// A stalled result channel fills the queue and then holds req_tready low.

module life_automaton_generation #(
   parameter int MAX_ROWS = lifegen_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [0] cell_alive
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,  // [0] next_alive
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,  // [0] board_done
   input  logic                                csr_we,
   input  logic [lifegen_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lifegen_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lifegen_pkg::work_type push_work, head_work;
   logic                  push_valid, push_ready, head_valid, head_pop;
   logic                  next_alive;

   lifegen_front #(
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (req_tvalid),
      .cell_alive (req_tdata[0]),
      .cell_ready (req_tready),
      .csr_we     (csr_we),
      .csr_index  (lifegen_pkg::csr_index_type'(csr_addr)),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_work  (push_work),
      .push_ready (push_ready)
   );

   lifegen_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_work  (push_work),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_work   (head_work),
      .pop        (head_pop)
   );

   lifegen_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (head_valid),
      .work_head  (head_work),
      .work_pop   (head_pop),
      .out_valid  (rsp_tvalid),
      .out_alive  (next_alive),
      .out_end    (rsp_tlast),
      .out_done   (rsp_tuser),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {7'b0, next_alive};

endmodule

[rtl/core/lifegen_checker.sv]
`timescale 1ns / 1ps

module lifegen_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_reset_opens_req: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("board end without end of run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result transaction changed");

endmodule

bind life_automaton_generation lifegen_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
